// ----- design/assert_macros.svh -----
// Assertion macros shared by the line and comment counter RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define CCL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define CCL_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define CCL_ASSERT(lbl, clk, rst_n, prop, msg)
`define CCL_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- design/ccl_pkg.sv -----
// Types and constants for the C source line and comment counter.
// No dependencies; imported by ccl_lexer, ccl_counters and the top level.
`default_nettype none

package ccl_pkg;

    localparam int OUT_W = 32;
    localparam int ST_W  = 4;

    // Lexer state codes
    localparam logic [ST_W-1:0] ST_CODE     = 4'd0;
    localparam logic [ST_W-1:0] ST_SLASH    = 4'd1;
    localparam logic [ST_W-1:0] ST_LINECMT  = 4'd2;
    localparam logic [ST_W-1:0] ST_BLOCK    = 4'd3;
    localparam logic [ST_W-1:0] ST_STAR     = 4'd4;
    localparam logic [ST_W-1:0] ST_STRING   = 4'd5;
    localparam logic [ST_W-1:0] ST_STR_ESC  = 4'd6;
    localparam logic [ST_W-1:0] ST_CHAR     = 4'd7;
    localparam logic [ST_W-1:0] ST_CHAR_ESC = 4'd8;
    localparam logic [ST_W-1:0] ST_DIRECT   = 4'd9;
    localparam logic [ST_W-1:0] ST_DIR_ESC  = 4'd10;

    // Characters of interest
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_byte;
    } t_ccl_in;

    typedef struct packed {
        logic [OUT_W-1:0] line_total;
        logic [OUT_W-1:0] code_line_total;
        logic [OUT_W-1:0] line_comment_total;
        logic [OUT_W-1:0] block_comment_total;
        logic [OUT_W-1:0] directive_total;
        logic             at_rest;
    } t_ccl_out;

    // Counter bumps raised by the lexer for one byte
    typedef struct packed {
        logic line;
        logic code_line;
        logic line_cmt;
        logic block_cmt;
        logic directive;
    } t_ccl_events;

endpackage

`default_nettype wire

// ----- design/ccl_lexer.sv -----
// Lexical state machine: state register, code-on-line flag, per-byte events.
// Depends on ccl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ccl_lexer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_adv,
    input  wire  [7:0]          i_byte,
    input  wire                 i_first,
    output ccl_pkg::t_ccl_events o_ev,
    output logic                o_at_rest
);
    import ccl_pkg::*;

    logic [ST_W-1:0] r_state, n_state;
    logic            r_flag, n_flag;
    logic [ST_W-1:0] st;
    logic            flag;
    logic            is_nl, is_blank;
    t_ccl_events     ev;

    assign st       = i_first ? ST_CODE : r_state;
    assign flag     = i_first ? 1'b0 : r_flag;
    assign is_nl    = (i_byte == CH_NL);
    assign is_blank = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));

    always_comb begin
        n_state = st;
        n_flag  = flag;
        ev      = '0;
        unique case (st) inside
            ST_CODE: begin
                if (is_nl) begin
                    ev.line      = 1'b1;
                    ev.code_line = flag;
                    n_flag       = 1'b0;
                end else if (is_blank) begin
                    n_flag = flag;
                end else if (i_byte == CH_SLASH) begin
                    n_state = ST_SLASH;
                end else if (i_byte == CH_DQUOTE) begin
                    n_flag  = 1'b1;
                    n_state = ST_STRING;
                end else if (i_byte == CH_SQUOTE) begin
                    n_flag  = 1'b1;
                    n_state = ST_CHAR;
                end else if (i_byte == CH_HASH) begin
                    ev.directive = 1'b1;
                    n_state      = ST_DIRECT;
                end else begin
                    n_flag = 1'b1;
                end
            end
            ST_SLASH: begin
                if (is_nl) begin
                    // lone slash is code, then the line ends
                    ev.line      = 1'b1;
                    ev.code_line = 1'b1;
                    n_flag       = 1'b0;
                    n_state      = ST_CODE;
                end else if (i_byte == CH_SLASH) begin
                    ev.line_cmt = 1'b1;
                    n_state     = ST_LINECMT;
                end else if (i_byte == CH_STAR) begin
                    ev.block_cmt = 1'b1;
                    n_state      = ST_BLOCK;
                end else begin
                    n_flag  = 1'b1;
                    n_state = ST_CODE;
                end
            end
            ST_LINECMT: begin
                if (is_nl) begin
                    ev.line      = 1'b1;
                    ev.code_line = flag;
                    n_flag       = 1'b0;
                    n_state      = ST_CODE;
                end
            end
            ST_BLOCK: begin
                if (is_nl) begin
                    ev.line      = 1'b1;
                    ev.code_line = flag;
                    n_flag       = 1'b0;
                end else if (i_byte == CH_STAR) begin
                    n_state = ST_STAR;
                end
            end
            ST_STAR: begin
                if (is_nl) begin
                    ev.line      = 1'b1;
                    ev.code_line = flag;
                    n_flag       = 1'b0;
                    n_state      = ST_BLOCK;
                end else if (i_byte == CH_SLASH) begin
                    n_state = ST_CODE;
                end else if (i_byte != CH_STAR) begin
                    n_state = ST_BLOCK;
                end
            end
            ST_STRING: begin
                if (i_byte == CH_DQUOTE) begin
                    n_state = ST_CODE;
                end else if (i_byte == CH_BSLASH) begin
                    n_state = ST_STR_ESC;
                end
            end
            ST_CHAR: begin
                if (i_byte == CH_SQUOTE) begin
                    n_state = ST_CODE;
                end else if (i_byte == CH_BSLASH) begin
                    n_state = ST_CHAR_ESC;
                end
            end
            ST_STR_ESC, ST_CHAR_ESC: begin
                // escaped newline still makes a code line
                if (is_nl) begin
                    ev.line      = 1'b1;
                    ev.code_line = 1'b1;
                    n_flag       = 1'b0;
                end
                n_state = (st == ST_STR_ESC) ? ST_STRING : ST_CHAR;
            end
            ST_DIRECT: begin
                if (is_nl) begin
                    ev.line = 1'b1;
                    n_flag  = 1'b0;
                    n_state = ST_CODE;
                end else if (i_byte == CH_BSLASH) begin
                    n_state = ST_DIR_ESC;
                end
            end
            ST_DIR_ESC: begin
                if (is_nl) begin
                    ev.line = 1'b1;
                    n_flag  = 1'b0;
                end
                n_state = ST_DIRECT;
            end
            default: begin
                n_state = ST_CODE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CODE;
            r_flag  <= 1'b0;
        end else if (i_adv) begin
            r_state <= n_state;
            r_flag  <= n_flag;
        end
    end

    assign o_ev      = i_adv ? ev : '0;
    assign o_at_rest = (r_state == ST_CODE);

    // a completed line always leaves the code flag clear
    `CCL_ASSERT(a_line_clears_flag, i_clk, i_rst_n, (i_adv && ev.line) |=> !r_flag, "code flag survived line end")
    // first byte forces a fresh start from plain code
    `CCL_NEVER(a_first_no_cmt_close, i_clk, i_rst_n, i_adv && i_first && (ev.block_cmt || ev.line_cmt), "comment opened without slash state")

endmodule

`default_nettype wire

// ----- design/ccl_counters.sv -----
// Saturating event counters, cleared by the first-byte flag.
// Depends on ccl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ccl_counters #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_adv,
    input  wire                    i_clr,
    input  ccl_pkg::t_ccl_events   i_ev,
    output logic [COUNT_WIDTH-1:0] o_lines,
    output logic [COUNT_WIDTH-1:0] o_code_lines,
    output logic [COUNT_WIDTH-1:0] o_line_cmts,
    output logic [COUNT_WIDTH-1:0] o_block_cmts,
    output logic [COUNT_WIDTH-1:0] o_directives
);
    import ccl_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic [COUNT_WIDTH-1:0] r_lines, r_code_lines, r_line_cmts, r_block_cmts, r_directives;
    logic [COUNT_WIDTH-1:0] n_lines, n_code_lines, n_line_cmts, n_block_cmts, n_directives;

    function automatic logic [COUNT_WIDTH-1:0] sat_bump(
        input logic [COUNT_WIDTH-1:0] cur,
        input logic                   clr,
        input logic                   inc
    );
        logic [COUNT_WIDTH-1:0] base;
        base = clr ? '0 : cur;
        return (inc && (base != CNT_MAX)) ? base + CNT_ONE : base;
    endfunction

    always_comb begin
        n_lines      = sat_bump(r_lines,      i_clr, i_ev.line);
        n_code_lines = sat_bump(r_code_lines, i_clr, i_ev.code_line);
        n_line_cmts  = sat_bump(r_line_cmts,  i_clr, i_ev.line_cmt);
        n_block_cmts = sat_bump(r_block_cmts, i_clr, i_ev.block_cmt);
        n_directives = sat_bump(r_directives, i_clr, i_ev.directive);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines      <= '0;
            r_code_lines <= '0;
            r_line_cmts  <= '0;
            r_block_cmts <= '0;
            r_directives <= '0;
        end else if (i_adv) begin
            r_lines      <= n_lines;
            r_code_lines <= n_code_lines;
            r_line_cmts  <= n_line_cmts;
            r_block_cmts <= n_block_cmts;
            r_directives <= n_directives;
        end
    end

    assign o_lines      = r_lines;
    assign o_code_lines = r_code_lines;
    assign o_line_cmts  = r_line_cmts;
    assign o_block_cmts = r_block_cmts;
    assign o_directives = r_directives;

    // code lines are a subset of lines, saturation included
    `CCL_NEVER(a_code_le_lines, i_clk, i_rst_n, r_code_lines > r_lines, "more code lines than lines")
    // counts only grow between clears
    `CCL_ASSERT(a_lines_monotonic, i_clk, i_rst_n, (i_adv && !i_clr) |=> (r_lines >= $past(r_lines)), "line count went backwards")

endmodule

`default_nettype wire

// ----- design/c_source_line_comment_counter_core.sv -----
// Top level of the C source line and comment counter.
// Depends on ccl_pkg, ccl_lexer, ccl_counters and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Byte-at-a-time C source lexer that keeps running totals of lines, lines
// holding code, // comments, /* comments and preprocessor directives, and
// reports them, with an at-rest flag for plain code, after every byte. One
// byte is taken per clock cycle while the result side is not stalled; each
// result passes through the input register, then the lexer state and counter
// registers, which double as the result register. Throughput is set by the
// single lexer state register, updated once per byte. Back-pressure on the
// result side stalls the pipe; the input register keeps accepting until it is
// full. A byte with first_byte set clears all counts and the lexer state before
// it is handled. Counters are COUNT_WIDTH bits wide, saturate at their maximum,
// and the low 32 bits are reported (zero-extended when narrower).
module c_source_line_comment_counter_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  ccl_pkg::t_ccl_in   i_data,
    output logic               o_valid,
    input  wire                i_ready,
    output ccl_pkg::t_ccl_out  o_data
);
    import ccl_pkg::*;

    logic                   r_in_valid;
    t_ccl_in                r_in;
    logic                   r_out_valid;
    logic                   adv;
    t_ccl_events            ev;
    logic                   at_rest;
    logic [COUNT_WIDTH-1:0] lines, code_lines, line_cmts, block_cmts, directives;

    // process the held byte when the result slot is free or being emptied
    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    ccl_lexer u_lexer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_byte    (r_in.byte_value),
        .i_first   (r_in.first_byte),
        .o_ev      (ev),
        .o_at_rest (at_rest)
    );

    ccl_counters #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counters (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_clr        (r_in.first_byte),
        .i_ev         (ev),
        .o_lines      (lines),
        .o_code_lines (code_lines),
        .o_line_cmts  (line_cmts),
        .o_block_cmts (block_cmts),
        .o_directives (directives)
    );

    // state and counter registers hold the result until its transfer
    assign o_valid                    = r_out_valid;
    assign o_data.line_total          = OUT_W'(lines);
    assign o_data.code_line_total     = OUT_W'(code_lines);
    assign o_data.line_comment_total  = OUT_W'(line_cmts);
    assign o_data.block_comment_total = OUT_W'(block_cmts);
    assign o_data.directive_total     = OUT_W'(directives);
    assign o_data.at_rest             = at_rest;

    // a held byte is never dropped or overwritten while the pipe is stalled
    `CCL_ASSERT(a_in_hold, i_clk, i_rst_n, (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in)), "held byte lost")
    // a stalled result keeps its counts
    `CCL_ASSERT(a_out_hold, i_clk, i_rst_n, (r_out_valid && !i_ready) |=> (r_out_valid && $stable(lines)), "stalled result changed")

endmodule

`default_nettype wire

// ----- verif/ccl_count_checker.sv -----
// Checker for the C source line and comment counter: watches both channels, predicts totals.
// Depends on ccl_pkg for the transfer types, the lexer state codes and the character codes.
`timescale 1ns / 100ps

module ccl_count_checker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_ready,
    input  ccl_pkg::t_ccl_in   i_in_data,
    input  wire                i_out_valid,
    input  wire                i_out_ready,
    input  ccl_pkg::t_ccl_out  i_out_data,
    output int                 o_backlog,
    output int                 o_fail_count
);
    import ccl_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Predicted lexer state and running totals
    logic [ST_W-1:0]  lex_mode;
    logic             on_code_line;
    logic [OUT_W-1:0] n_lines;
    logic [OUT_W-1:0] n_code_lines;
    logic [OUT_W-1:0] n_line_cmts;
    logic [OUT_W-1:0] n_block_cmts;
    logic [OUT_W-1:0] n_directives;

    t_ccl_out expected_totals[$];
    int       fails = 0;

    function automatic logic [OUT_W-1:0] sat_inc(input logic [OUT_W-1:0] c);
        return (c == '1) ? c : c + OUT_W'(1);
    endfunction

    function automatic void clear_lexer();
        lex_mode     = ST_CODE;
        on_code_line = 1'b0;
        n_lines      = '0;
        n_code_lines = '0;
        n_line_cmts  = '0;
        n_block_cmts = '0;
        n_directives = '0;
    endfunction

    function automatic void close_line();
        n_lines = sat_inc(n_lines);
        if (on_code_line)
            n_code_lines = sat_inc(n_code_lines);
        on_code_line = 1'b0;
    endfunction

    function automatic t_ccl_out lex_byte(input t_ccl_in item);
        logic [7:0] ch;
        t_ccl_out   res;
        ch = item.byte_value;
        if (item.first_byte)
            clear_lexer();
        case (lex_mode) inside
            ST_CODE: begin
                if (ch == CH_NL) begin
                    close_line();
                end else if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
                end else if (ch == CH_SLASH) begin
                    lex_mode = ST_SLASH;
                end else if (ch == CH_DQUOTE) begin
                    on_code_line = 1'b1;
                    lex_mode = ST_STRING;
                end else if (ch == CH_SQUOTE) begin
                    on_code_line = 1'b1;
                    lex_mode = ST_CHAR;
                end else if (ch == CH_HASH) begin
                    n_directives = sat_inc(n_directives);
                    lex_mode = ST_DIRECT;
                end else begin
                    on_code_line = 1'b1;
                end
            end
            ST_SLASH: begin
                if (ch == CH_NL) begin
                    on_code_line = 1'b1;
                    close_line();
                    lex_mode = ST_CODE;
                end else if (ch == CH_SLASH) begin
                    n_line_cmts = sat_inc(n_line_cmts);
                    lex_mode = ST_LINECMT;
                end else if (ch == CH_STAR) begin
                    n_block_cmts = sat_inc(n_block_cmts);
                    lex_mode = ST_BLOCK;
                end else begin
                    // lone slash: the following byte is swallowed
                    on_code_line = 1'b1;
                    lex_mode = ST_CODE;
                end
            end
            ST_LINECMT: begin
                if (ch == CH_NL) begin
                    close_line();
                    lex_mode = ST_CODE;
                end
            end
            ST_BLOCK: begin
                if (ch == CH_NL)
                    close_line();
                else if (ch == CH_STAR)
                    lex_mode = ST_STAR;
            end
            ST_STAR: begin
                if (ch == CH_NL) begin
                    close_line();
                    lex_mode = ST_BLOCK;
                end else if (ch == CH_SLASH) begin
                    lex_mode = ST_CODE;
                end else if (ch != CH_STAR) begin
                    lex_mode = ST_BLOCK;
                end
            end
            ST_STRING: begin
                if (ch == CH_DQUOTE)
                    lex_mode = ST_CODE;
                else if (ch == CH_BSLASH)
                    lex_mode = ST_STR_ESC;
            end
            ST_CHAR: begin
                if (ch == CH_SQUOTE)
                    lex_mode = ST_CODE;
                else if (ch == CH_BSLASH)
                    lex_mode = ST_CHAR_ESC;
            end
            ST_STR_ESC, ST_CHAR_ESC: begin
                if (ch == CH_NL) begin
                    on_code_line = 1'b1;
                    close_line();
                end
                lex_mode = (lex_mode == ST_STR_ESC) ? ST_STRING : ST_CHAR;
            end
            ST_DIRECT: begin
                if (ch == CH_NL) begin
                    n_lines = sat_inc(n_lines);
                    on_code_line = 1'b0;
                    lex_mode = ST_CODE;
                end else if (ch == CH_BSLASH) begin
                    lex_mode = ST_DIR_ESC;
                end
            end
            ST_DIR_ESC: begin
                if (ch == CH_NL) begin
                    n_lines = sat_inc(n_lines);
                    on_code_line = 1'b0;
                end
                lex_mode = ST_DIRECT;
            end
            default: lex_mode = ST_CODE;
        endcase
        res.line_total          = n_lines;
        res.code_line_total     = n_code_lines;
        res.line_comment_total  = n_line_cmts;
        res.block_comment_total = n_block_cmts;
        res.directive_total     = n_directives;
        res.at_rest             = (lex_mode == ST_CODE);
        return res;
    endfunction

    always @(posedge i_clk) begin : track
        t_ccl_out want;
        t_ccl_out got;
        logic     bad;
        if (!i_rst_n) begin
            clear_lexer();
            expected_totals.delete();
        end else begin
            // compare before predicting: a result can never share an edge with its own byte
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_totals.size() == 0) begin
                    if (fails < REPORT_LIMIT)
                        $display("%t: result with nothing expected: lines %0d code %0d //%0d /*%0d #%0d rest %0b",
                                 $realtime, got.line_total, got.code_line_total,
                                 got.line_comment_total, got.block_comment_total,
                                 got.directive_total, got.at_rest);
                    fails++;
                end else begin
                    want = expected_totals.pop_front();
                    bad = (got.line_total          !== want.line_total)
                       || (got.code_line_total     !== want.code_line_total)
                       || (got.line_comment_total  !== want.line_comment_total)
                       || (got.block_comment_total !== want.block_comment_total)
                       || (got.directive_total     !== want.directive_total)
                       || (got.at_rest             !== want.at_rest);
                    if (bad) begin
                        if (fails < REPORT_LIMIT)
                            $display({"%t: mismatch, expected/actual: lines %0d/%0d code %0d/%0d",
                                      " //%0d/%0d /*%0d/%0d #%0d/%0d rest %0b/%0b"},
                                     $realtime, want.line_total, got.line_total,
                                     want.code_line_total, got.code_line_total,
                                     want.line_comment_total, got.line_comment_total,
                                     want.block_comment_total, got.block_comment_total,
                                     want.directive_total, got.directive_total,
                                     want.at_rest, got.at_rest);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_totals.push_back(lex_byte(i_in_data));
        end
        o_backlog    <= expected_totals.size();
        o_fail_count <= fails;
    end

endmodule

// ----- verif/c_source_line_comment_counter_core_test.sv -----
// Top level of the line and comment counter testbench: clock, reset, byte stimulus, verdict.
// Depends on ccl_pkg, the c_source_line_comment_counter_core RTL and ccl_count_checker.
`timescale 1ns / 100ps

module c_source_line_comment_counter_core_test;
    import ccl_pkg::*;

    localparam int SOURCE_BYTES   = 2000;  // random text after the opening bytes
    localparam int HOLD_AT        = 400;   // bytes sent before the long result stall
    localparam int DRAIN_AT       = 900;   // bytes sent before the full drain pause
    localparam int QUIET_AT       = 1700;  // no idling on either side from here on
    localparam int LONG_HOLD      = 300;   // cycles of result back-pressure
    localparam int RESULT_LATENCY = 2;
    localparam int STALL_LIMIT    = 2000;  // cycles without any transfer

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    t_ccl_in  i_data  = '0;
    logic     i_ready = 1'b0;
    logic     o_ready;
    logic     o_valid;
    t_ccl_out o_data;

    int backlog;
    int fail_count;
    int items_sent = 0;

    // both written by the byte source only, read by the result sink
    logic gaps_on       = 1'b1;
    logic long_hold_req = 1'b0;

    // Opening bytes: extreme byte values, lone slash, slash-newline, a line comment, a
    // multi-line block comment closed by a double star, a string with an escaped
    // newline, a char constant with an escaped quote, and a continued directive.
    logic [7:0] opening_text [0:27] = '{
        8'hFF, CH_SLASH, 8'h61, CH_SLASH, CH_NL,
        CH_SLASH, CH_SLASH, 8'h00, CH_NL,
        CH_SLASH, CH_STAR, CH_NL, CH_STAR, CH_STAR, CH_SLASH,
        CH_DQUOTE, CH_BSLASH, CH_NL, CH_DQUOTE,
        CH_SQUOTE, CH_BSLASH, CH_SQUOTE, CH_SQUOTE,
        CH_HASH, CH_BSLASH, CH_NL, CH_TAB, CH_NL
    };

    always #1 i_clk = ~i_clk;

    c_source_line_comment_counter_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    ccl_count_checker checker_0 (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_backlog    (backlog),
        .o_fail_count (fail_count)
    );

    function automatic logic [7:0] pick_byte(input int lo, input int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    // Offer one byte and hold it until the transfer. Valid is only dropped for an
    // idle burst, so it is never lowered and raised within the same time step.
    task automatic send_item(input logic [7:0] ch, input logic clear);
        i_valid <= 1'b1;
        i_data  <= '{byte_value: ch, first_byte: clear};
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        items_sent++;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge i_clk);
        end
    endtask

    // Random bytes occasionally restart the count mid-stream
    task automatic send_char(input logic [7:0] ch);
        send_item(ch, $urandom_range(0, 299) == 0);
    endtask

    // Wait until every transfer sent has come back; the backlog is registered
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (backlog != 0)
            @(posedge i_clk);
    endtask

    // One lexical fragment of plausible C text, plus some raw noise
    task automatic emit_fragment();
        int n;
        case ($urandom_range(0, 11))
            0, 1: begin
                // identifiers and operators
                repeat ($urandom_range(1, 6))
                    send_char(pick_byte(8'h30, 8'h7A));
            end
            2: send_char(CH_NL);
            3: begin
                // whitespace, including vertical tab and form feed
                repeat ($urandom_range(1, 3))
                    send_char($urandom_range(0, 1) ? CH_SPACE : pick_byte(CH_TAB, CH_CR));
            end
            4: begin
                send_char(CH_SLASH);
                send_char(CH_SLASH);
                repeat ($urandom_range(0, 8))
                    send_char(pick_byte(8'h20, 8'hFF));
                send_char(CH_NL);
            end
            5: begin
                send_char(CH_SLASH);
                send_char(CH_STAR);
                n = $urandom_range(0, 10);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0:       send_char(CH_NL);
                        1:       send_char(CH_STAR);
                        default: send_char(pick_byte(8'h20, 8'h7E));
                    endcase
                end
                // one or more stars before the closing slash
                repeat ($urandom_range(1, 3))
                    send_char(CH_STAR);
                send_char(CH_SLASH);
            end
            6: begin
                send_char(CH_DQUOTE);
                repeat ($urandom_range(0, 8)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_char(CH_BSLASH);
                        send_char($urandom_range(0, 2) == 0 ? CH_NL : pick_byte(8'h00, 8'hFF));
                    end else begin
                        send_char(pick_byte(8'h20, 8'h7E));
                    end
                end
                send_char(CH_DQUOTE);
            end
            7: begin
                send_char(CH_SQUOTE);
                if ($urandom_range(0, 1))
                    send_char(CH_BSLASH);
                send_char($urandom_range(0, 3) == 0 ? CH_NL : pick_byte(8'h20, 8'h7E));
                send_char(CH_SQUOTE);
            end
            8: begin
                send_char(CH_HASH);
                repeat ($urandom_range(0, 6))
                    send_char(pick_byte(8'h20, 8'h7E));
                if ($urandom_range(0, 2) == 0) begin
                    // continued onto the next line
                    send_char(CH_BSLASH);
                    send_char(CH_NL);
                    repeat ($urandom_range(0, 4))
                        send_char(pick_byte(8'h20, 8'h7E));
                end
                send_char(CH_NL);
            end
            9: begin
                send_char(CH_SLASH);
                send_char(pick_byte(8'h00, 8'hFF));
            end
            default: begin
                repeat ($urandom_range(1, 4))
                    send_char(pick_byte(8'h00, 8'hFF));
            end
        endcase
    endtask

    // Byte source and verdict
    initial begin : byte_source
        logic drained;
        drained = 1'b0;
        repeat (5)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_text[k])
            send_item(opening_text[k], k == 0);

        while (items_sent < SOURCE_BYTES) begin
            if (items_sent >= HOLD_AT)
                long_hold_req <= 1'b1;
            if (items_sent >= DRAIN_AT && !drained) begin
                // source pause until all outstanding totals are back
                wait_for_drain();
                drained = 1'b1;
            end
            if (items_sent >= QUIET_AT)
                gaps_on <= 1'b0;
            emit_fragment();
        end

        wait_for_drain();
        repeat (4 * RESULT_LATENCY)
            @(posedge i_clk);
        if (fail_count == 0 && backlog == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result sink: random back-pressure bursts, and one long hold so the
    // input side fills up and stalls while bytes keep being offered.
    initial begin : result_sink
        logic held_long;
        held_long = 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req && !held_long) begin
                held_long = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD)
                    @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 12))
                    @(posedge i_clk);
            end
        end
    end

    // Watchdog: any transfer on either channel restarts the count
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
